// ----- rtl/blur3_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the 3x3 rgb box blur
package blur3_pkg;

   localparam int PIX_W            = 24;
   localparam int LINE_W           = 2 * PIX_W;
   localparam int CSR_DATA_W       = 11;
   localparam int COL_SUM_W        = 10;
   localparam int ACC_W            = 12;
   localparam int POS_W            = 10;
   localparam int NUM_CELLS        = 2;
   localparam int FRAME_WIDTH_RST  = 800;
   localparam int FRAME_HEIGHT_RST = 600;
   // q = (t * 7282) >> 16 equals t / 9 for every t up to 9 * 3 * 255
   localparam int DIV9_MUL         = 7282;
   localparam int DIV9_SHIFT       = 16;
   localparam int PROD_W           = 25;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [0:0] {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_red;
      logic [7:0]       out_green;
      logic [7:0]       out_blue;
      logic [7:0]       out_alpha;
      logic [POS_W-1:0] out_column;
      logic [POS_W-1:0] out_row;
      logic             frame_last;
   } rsp_type;

   // per-channel sum over one window column
   typedef struct packed {
      logic [COL_SUM_W-1:0] red;
      logic [COL_SUM_W-1:0] green;
      logic [COL_SUM_W-1:0] blue;
   } chan_sum_type;

   // per-channel running sum along the cell chain
   typedef struct packed {
      logic [ACC_W-1:0] red;
      logic [ACC_W-1:0] green;
      logic [ACC_W-1:0] blue;
   } chan_acc_type;

endpackage

// ----- rtl/blur3_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read (read-first)
module blur3_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/blur3_cell.sv -----
`timescale 1ns / 1ps
// one window column cell: holds a column sum, passes it on, adds it to the chain sum
module blur3_cell (
   input  logic                   clock,
   input  logic                   load,
   input  logic                   clear,
   input  blur3_pkg::chan_sum_type col_in,
   input  blur3_pkg::chan_acc_type acc_in,
   output blur3_pkg::chan_sum_type col_out,
   output blur3_pkg::chan_acc_type acc_out
);

   blur3_pkg::chan_sum_type col_ff;
   blur3_pkg::chan_sum_type col_in_sel;

   always_comb begin
      col_in_sel = clear ? '0 : col_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         col_ff <= col_in_sel;
      end
   end

   always_comb begin
      col_out       = col_ff;
      acc_out.red   = acc_in.red   + blur3_pkg::ACC_W'(col_ff.red);
      acc_out.green = acc_in.green + blur3_pkg::ACC_W'(col_ff.green);
      acc_out.blue  = acc_in.blue  + blur3_pkg::ACC_W'(col_ff.blue);
   end

endmodule

// ----- rtl/box_blur_3x3_rgb.sv -----
`timescale 1ns / 1ps
// top level of the 3x3 rgb box blur
// Takes one pixel item per clock in raster order and returns the blurred pixel
// (r,c) when the item W+1 positions later is accepted, W being the frame width;
// W+1 drain items after the last pixel flush the frame. Pixels outside the frame
// count as black, so edge pixels come out darker. A result leaves the block once
// its item has passed the registered line memory read, window sum and divide by
// nine into the output register. The rate is one item per clock, set by the one
// read and one write of the shared line memory per item; input stalls only while
// a finished result waits, the next is ready behind it and the read stage item emits.
// Writing frame_width or frame_height restarts the frame; values of zero act as
// one and values beyond MAX_WIDTH or MAX_HEIGHT act as that maximum.
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  blur3_pkg::req_type              req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output blur3_pkg::rsp_type              rsp_payload,
   input  logic                            csr_we,
   input  blur3_pkg::csr_index_type        csr_index,
   input  logic [blur3_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int YW  = $clog2(MAX_HEIGHT + 2);
   localparam int YCW = YW + 1;
   localparam int CW  = (WW > HW ? WW : HW) + blur3_pkg::CSR_DATA_W;
   localparam int RST_W = (blur3_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                          MAX_WIDTH : blur3_pkg::FRAME_WIDTH_RST;
   localparam int RST_H = (blur3_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                          MAX_HEIGHT : blur3_pkg::FRAME_HEIGHT_RST;
   localparam int PW = blur3_pkg::PIX_W;

   // configuration and input position
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [CW-1:0] csr_ext;

   // front end decode
   logic           restart;
   logic [XW-1:0]  cur_col;
   logic [YW-1:0]  cur_row;
   logic [YCW-1:0] y_c;
   logic [YCW-1:0] h_e;
   logic           in_frame;
   logic           top_ok;
   logic           mid_ok;
   logic           col_zero;
   logic           emit;
   logic           last;
   logic [PW-1:0]  pixel;
   logic [YCW-1:0] erow;
   logic [WW-1:0]  ecol;
   logic [WW-1:0]  col_step;
   logic [YCW+blur3_pkg::POS_W-1:0] erow_ext;
   logic [WW+blur3_pkg::POS_W-1:0]  ecol_ext;
   logic           accept;

   // stage 1: line memory read in flight
   logic                          v1_ff, v1_in;
   logic [PW-1:0]                 pix1_ff;
   logic                          top_ok1_ff;
   logic                          mid_ok1_ff;
   logic                          col_zero1_ff;
   logic                          emit1_ff;
   logic                          we1_ff;
   logic                          last1_ff;
   logic [XW-1:0]                 addr1_ff;
   logic [blur3_pkg::POS_W-1:0]   row1_ff;
   logic [blur3_pkg::POS_W-1:0]   col1_ff;
   logic                          fwd1_ff;
   logic [blur3_pkg::LINE_W-1:0]  fwd_data1_ff;
   logic                          fwd_in;
   logic [blur3_pkg::LINE_W-1:0]  ram_rd;
   logic [blur3_pkg::LINE_W-1:0]  line_rd;
   logic [blur3_pkg::LINE_W-1:0]  wr_data;
   logic [PW-1:0]                 upper;
   logic [PW-1:0]                 lower;
   logic [PW-1:0]                 top;
   logic [PW-1:0]                 mid;
   logic                          ram_we;
   logic                          adv1;

   // window cell chain
   blur3_pkg::chan_sum_type col_link [blur3_pkg::NUM_CELLS];
   blur3_pkg::chan_acc_type acc_link [blur3_pkg::NUM_CELLS + 1];

   // stage 2: window total
   logic                        v2_ff, v2_in;
   blur3_pkg::chan_acc_type     tot2_ff;
   logic [blur3_pkg::POS_W-1:0] row2_ff;
   logic [blur3_pkg::POS_W-1:0] col2_ff;
   logic                        last2_ff;
   logic                        adv2;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   blur3_pkg::rsp_type           rsp_payload_ff;
   blur3_pkg::rsp_type           rsp_payload_in;
   logic [blur3_pkg::PROD_W-1:0] prod_red;
   logic [blur3_pkg::PROD_W-1:0] prod_green;
   logic [blur3_pkg::PROD_W-1:0] prod_blue;

   // ---------------------------------------------------------------- handshake
   always_comb begin
      adv2      = v2_ff && (!rsp_valid_ff || !rsp_stall);
      adv1      = v1_ff && (!emit1_ff || !v2_ff || adv2);
      req_stall = v1_ff && !adv1;
      accept    = req_valid && !req_stall;
   end

   // ---------------------------------------------------------------- front end
   always_comb begin
      h_e      = YCW'(height_ff);
      restart  = (WW'(col_ff) >= width_ff) || (YCW'(row_ff) > h_e + YCW'(1));
      cur_col  = restart ? '0 : col_ff;
      cur_row  = restart ? '0 : row_ff;
      y_c      = YCW'(cur_row);
      in_frame = y_c < h_e;
      top_ok   = (y_c >= YCW'(2)) && (y_c < h_e + YCW'(2));
      mid_ok   = (y_c >= YCW'(1)) && (y_c < h_e + YCW'(1));
      col_zero = (cur_col == '0);
      // a row start closes the last pixel of the row two up
      emit     = col_zero ? top_ok : mid_ok;
      last     = col_zero && (y_c == h_e + YCW'(1));
      if ((req_payload.op == blur3_pkg::OP_PIXEL) && in_frame) begin
         pixel = {req_payload.src_red, req_payload.src_green, req_payload.src_blue};
      end else begin
         pixel = '0;
      end
      erow     = col_zero ? (y_c - YCW'(2)) : (y_c - YCW'(1));
      ecol     = col_zero ? (width_ff - WW'(1)) : (WW'(cur_col) - WW'(1));
      erow_ext = (YCW + blur3_pkg::POS_W)'(erow);
      ecol_ext = (WW + blur3_pkg::POS_W)'(ecol);
      col_step = WW'(cur_col) + WW'(1);
      csr_ext  = CW'(csr_data);
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
         case (csr_index)
            blur3_pkg::CSR_FRAME_WIDTH: begin
               if (csr_ext == '0) begin
                  width_in = WW'(1);
               end else if (csr_ext > CW'(MAX_WIDTH)) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = csr_ext[WW-1:0];
               end
            end
            blur3_pkg::CSR_FRAME_HEIGHT: begin
               if (csr_ext == '0) begin
                  height_in = HW'(1);
               end else if (csr_ext > CW'(MAX_HEIGHT)) begin
                  height_in = HW'(MAX_HEIGHT);
               end else begin
                  height_in = csr_ext[HW-1:0];
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end else if (accept) begin
         if (emit && last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_step >= width_ff) begin
            col_in = '0;
            row_in = cur_row + YW'(1);
         end else begin
            col_in = col_step[XW-1:0];
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(RST_W);
         height_ff <= HW'(RST_H);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // same-column item right behind a write sees the write data, not the ram
   assign fwd_in = adv1 && we1_ff && (addr1_ff == cur_col);
   assign v1_in  = accept || (v1_ff && !adv1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff      <= pixel;
         top_ok1_ff   <= top_ok;
         mid_ok1_ff   <= mid_ok;
         col_zero1_ff <= col_zero;
         emit1_ff     <= emit;
         we1_ff       <= in_frame;
         last1_ff     <= last;
         addr1_ff     <= cur_col;
         row1_ff      <= erow_ext[blur3_pkg::POS_W-1:0];
         col1_ff      <= ecol_ext[blur3_pkg::POS_W-1:0];
         fwd1_ff      <= fwd_in;
         fwd_data1_ff <= wr_data;
      end
   end

   blur3_ram #(
      .WIDTH (blur3_pkg::LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr1_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (ram_rd)
   );

   always_comb begin
      line_rd = fwd1_ff ? fwd_data1_ff : ram_rd;
      upper   = line_rd[2*PW-1:PW];
      lower   = line_rd[PW-1:0];
      top     = top_ok1_ff ? upper : '0;
      mid     = mid_ok1_ff ? lower : '0;
      // upper line takes the old lower line, lower line takes the new pixel
      wr_data = {lower, pix1_ff};
      ram_we  = adv1 && we1_ff;
   end

   // ---------------------------------------------------------------- window cells
   always_comb begin
      col_link[0].red   = blur3_pkg::COL_SUM_W'(top[23:16]) +
                          blur3_pkg::COL_SUM_W'(mid[23:16]) +
                          blur3_pkg::COL_SUM_W'(pix1_ff[23:16]);
      col_link[0].green = blur3_pkg::COL_SUM_W'(top[15:8]) +
                          blur3_pkg::COL_SUM_W'(mid[15:8]) +
                          blur3_pkg::COL_SUM_W'(pix1_ff[15:8]);
      col_link[0].blue  = blur3_pkg::COL_SUM_W'(top[7:0]) +
                          blur3_pkg::COL_SUM_W'(mid[7:0]) +
                          blur3_pkg::COL_SUM_W'(pix1_ff[7:0]);
      // at a row start the new column lies past the right edge of the emitted pixel
      if (col_zero1_ff) begin
         acc_link[0] = '0;
      end else begin
         acc_link[0].red   = blur3_pkg::ACC_W'(col_link[0].red);
         acc_link[0].green = blur3_pkg::ACC_W'(col_link[0].green);
         acc_link[0].blue  = blur3_pkg::ACC_W'(col_link[0].blue);
      end
   end

   for (genvar k = 0; k < blur3_pkg::NUM_CELLS; k++) begin : g_cell
      if (k < blur3_pkg::NUM_CELLS - 1) begin : g_mid
         blur3_cell u_cell (
            .clock   (clock),
            .load    (adv1),
            .clear   (1'b0),
            .col_in  (col_link[k]),
            .acc_in  (acc_link[k]),
            .col_out (col_link[k+1]),
            .acc_out (acc_link[k+1])
         );
      end else begin : g_end
         blur3_cell u_cell (
            .clock   (clock),
            .load    (adv1),
            .clear   (col_zero1_ff),
            .col_in  (col_link[k]),
            .acc_in  (acc_link[k]),
            .col_out (),
            .acc_out (acc_link[k+1])
         );
      end
   end

   // ---------------------------------------------------------------- stage 2
   assign v2_in = (adv1 && emit1_ff) || (v2_ff && !adv2);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && emit1_ff) begin
         tot2_ff  <= acc_link[blur3_pkg::NUM_CELLS];
         row2_ff  <= row1_ff;
         col2_ff  <= col1_ff;
         last2_ff <= last1_ff;
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      prod_red   = blur3_pkg::PROD_W'(tot2_ff.red) *
                   blur3_pkg::PROD_W'(blur3_pkg::DIV9_MUL);
      prod_green = blur3_pkg::PROD_W'(tot2_ff.green) *
                   blur3_pkg::PROD_W'(blur3_pkg::DIV9_MUL);
      prod_blue  = blur3_pkg::PROD_W'(tot2_ff.blue) *
                   blur3_pkg::PROD_W'(blur3_pkg::DIV9_MUL);
      rsp_payload_in.out_red    = prod_red[blur3_pkg::DIV9_SHIFT +: 8];
      rsp_payload_in.out_green  = prod_green[blur3_pkg::DIV9_SHIFT +: 8];
      rsp_payload_in.out_blue   = prod_blue[blur3_pkg::DIV9_SHIFT +: 8];
      rsp_payload_in.out_alpha  = blur3_pkg::ALPHA_OPAQUE;
      rsp_payload_in.out_column = col2_ff;
      rsp_payload_in.out_row    = row2_ff;
      rsp_payload_in.frame_last = last2_ff;
      rsp_valid_in              = adv2 || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- rtl/blur3_check.sv -----
`timescale 1ns / 1ps
// port-level checks for the 3x3 rgb box blur, bound to the top level
module blur3_check (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input blur3_pkg::rsp_type rsp_payload
);

   // a held result keeps its value until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.out_alpha == blur3_pkg::ALPHA_OPAQUE)
      else $error("alpha not opaque");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // input only backs up behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with the output free");

endmodule

bind box_blur_3x3_rgb blur3_check u_blur3_check (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the 3x3 rgb box blur with a built-in blur predictor
module tb_top;
   import blur3_pkg::*;

   localparam int LINE_MAX    = 1024;
   localparam int SETTLE      = 8;
   localparam int STALL_LIMIT = 500;
   localparam int RAND_ITEMS  = 1300;

   typedef struct packed {
      bit            is_cfg;
      csr_index_type idx;
      logic [10:0]   data;
      req_type       req;
      bit            has_exp;
      rsp_type       exp;
   } plan_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int unsigned errors = 0;
   int unsigned quiet_cycles = 0;
   int unsigned rsp_hold = 0;
   bit          tx_idle = 1'b1;
   bit          rx_idle = 1'b1;
   rsp_type     blur_expected [$];
   plan_row     directed_plan [$];

   // predictor state
   logic [23:0] row_two_above [LINE_MAX];
   logic [23:0] row_above [LINE_MAX];
   logic [23:0] blur_window [3][3];
   int unsigned cur_col, cur_row;
   int unsigned cfg_width_raw, cfg_height_raw;

   box_blur_3x3_rgb DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned eff_size(int unsigned v);
      if (v == 0) return 1;
      if (v > LINE_MAX) return LINE_MAX;
      return v;
   endfunction

   function automatic void clear_frame();
      foreach (blur_window[r, c]) blur_window[r][c] = '0;
      cur_col = 0;
      cur_row = 0;
   endfunction

   function automatic void shift_window(logic [23:0] top, logic [23:0] mid, logic [23:0] bot);
      for (int r = 0; r < 3; r++) begin
         blur_window[r][0] = blur_window[r][1];
         blur_window[r][1] = blur_window[r][2];
      end
      blur_window[0][2] = top;
      blur_window[1][2] = mid;
      blur_window[2][2] = bot;
   endfunction

   function automatic rsp_type window_avg(int unsigned row, int unsigned col, bit last);
      int unsigned sr, sg, sb;
      rsp_type     o;
      sr = 0;
      sg = 0;
      sb = 0;
      foreach (blur_window[r, c]) begin
         sr += blur_window[r][c][23:16];
         sg += blur_window[r][c][15:8];
         sb += blur_window[r][c][7:0];
      end
      o.out_red    = 8'(sr / 9);
      o.out_green  = 8'(sg / 9);
      o.out_blue   = 8'(sb / 9);
      o.out_alpha  = ALPHA_OPAQUE;
      o.out_column = POS_W'(col);
      o.out_row    = POS_W'(row);
      o.frame_last = last;
      return o;
   endfunction

   // advances the predictor by one item; returns 1 when a blurred pixel comes out
   function automatic bit blur_step(input req_type item, output rsp_type res);
      int unsigned w, h, x, y;
      logic [23:0] pix, top, mid, bot;
      bit          hit, last;
      w   = eff_size(cfg_width_raw);
      h   = eff_size(cfg_height_raw);
      x   = cur_col;
      y   = cur_row;
      pix = '0;
      hit = 1'b0;
      res = '0;
      if (x >= w || y > h + 1) begin
         clear_frame();
         x = 0;
         y = 0;
      end
      if (item.op == OP_PIXEL && y < h) pix = {item.src_red, item.src_green, item.src_blue};
      top = (y >= 2 && y - 2 < h) ? row_two_above[x] : '0;
      mid = (y >= 1 && y - 1 < h) ? row_above[x] : '0;
      bot = (y < h) ? pix : '0;
      if (y < h) begin
         row_two_above[x] = row_above[x];
         row_above[x]     = pix;
      end
      if (x == 0) begin
         // right edge of the row two above is finished when a new row starts
         shift_window('0, '0, '0);
         if (y >= 2 && y - 2 < h) begin
            last = (y - 2 == h - 1);
            res  = window_avg(y - 2, w - 1, last);
            hit  = 1'b1;
            if (last) begin
               clear_frame();
               return 1'b1;
            end
         end
         foreach (blur_window[r, c]) blur_window[r][c] = '0;
         blur_window[0][2] = top;
         blur_window[1][2] = mid;
         blur_window[2][2] = bot;
      end else begin
         shift_window(top, mid, bot);
         if (y >= 1 && y - 1 < h) begin
            res = window_avg(y - 1, x - 1, 1'b0);
            hit = 1'b1;
         end
      end
      x++;
      if (x >= w) begin
         x = 0;
         y++;
      end
      cur_col = x;
      cur_row = y;
      return hit;
   endfunction

   function automatic plan_row cfg_row(csr_index_type idx, logic [10:0] data);
      plan_row p;
      p        = '0;
      p.is_cfg = 1'b1;
      p.idx    = idx;
      p.data   = data;
      return p;
   endfunction

   function automatic plan_row item_row(op_type op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      plan_row p;
      p     = '0;
      p.req = {op, r, g, b};
      return p;
   endfunction

   // item whose blurred pixel is gray level v at (row, col)
   function automatic plan_row check_row(op_type op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic [7:0] v, logic [9:0] col, logic [9:0] row,
                                         bit last);
      plan_row p;
      p         = item_row(op, r, g, b);
      p.has_exp = 1'b1;
      p.exp     = {v, v, v, ALPHA_OPAQUE, col, row, last};
      return p;
   endfunction

   function automatic req_type random_req(op_type op);
      req_type q;
      q.op        = op;
      q.src_red   = 8'($urandom_range(0, 255));
      q.src_green = 8'($urandom_range(0, 255));
      q.src_blue  = 8'($urandom_range(0, 255));
      return q;
   endfunction

   function automatic logic [10:0] pick_size();
      case ($urandom_range(0, 19))
         0: return 11'd0;
         1: return 11'($urandom_range(1025, 2047));
         2, 3: return 11'($urandom_range(7, 20));
         default: return 11'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic send_item(input req_type item, input bit hold_off, input bit typed,
                            input rsp_type typed_val);
      int unsigned gap;
      rsp_type     res;
      bit          hit;
      gap = tx_idle ? $urandom_range(0, 4) : 0;
      if (hold_off && gap == 0) gap = 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         if (hold_off) while (blur_expected.size() != 0) @(posedge clock);
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hit = blur_step(item, res);
      if (typed) blur_expected.push_back(typed_val);
      else if (hit) blur_expected.push_back(res);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (blur_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [10:0] val);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) cfg_width_raw = val;
      else cfg_height_raw = val;
      clear_frame();
   endtask

   // in-frame positions get pixels, the flush tail gets drains; noise flips some of both
   task automatic send_frame(input int unsigned w, input int unsigned h, input int unsigned cut,
                             input bit noisy, input int unsigned pause_at);
      op_type op;
      for (int unsigned n = 0; n < cut; n++) begin
         if (n < w * h) op = (noisy && $urandom_range(0, 19) == 0) ? OP_DRAIN : OP_PIXEL;
         else op = (noisy && $urandom_range(0, 9) == 0) ? OP_PIXEL : OP_DRAIN;
         send_item(random_req(op), n == pause_at || (noisy && $urandom_range(0, 63) == 0),
                   1'b0, '0);
      end
   endtask

   task automatic check_field(input string name, input logic [9:0] exp, input logic [9:0] got);
      if (got !== exp) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, exp, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (blur_expected.size() == 0) begin
               errors++;
               $display("%0t: pixel expected none, got %h", $time, rsp_payload);
            end else begin
               e = blur_expected.pop_front();
               check_field("out_red", e.out_red, rsp_payload.out_red);
               check_field("out_green", e.out_green, rsp_payload.out_green);
               check_field("out_blue", e.out_blue, rsp_payload.out_blue);
               check_field("out_alpha", e.out_alpha, rsp_payload.out_alpha);
               check_field("out_column", e.out_column, rsp_payload.out_column);
               check_field("out_row", e.out_row, rsp_payload.out_row);
               check_field("frame_last", e.frame_last, rsp_payload.frame_last);
            end
            rsp_hold = rx_idle ? $urandom_range(0, 4) : 0;
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned w, h, len, cut, rand_sent;
      logic [10:0] w_raw, h_raw;
      foreach (row_two_above[i]) row_two_above[i] = '0;
      foreach (row_above[i]) row_above[i] = '0;
      cfg_width_raw  = FRAME_WIDTH_RST;
      cfg_height_raw = FRAME_HEIGHT_RST;
      clear_frame();
      rand_sent = 0;

      directed_plan = '{
         // 1x1 frames, zero sizes act as one
         cfg_row(CSR_FRAME_WIDTH, 11'd0),
         cfg_row(CSR_FRAME_HEIGHT, 11'd0),
         item_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF),
         item_row(OP_DRAIN, 8'h00, 8'h00, 8'h00),
         check_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'd28, 10'd0, 10'd0, 1'b1),
         // drain inside the frame is black
         item_row(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF),
         item_row(OP_DRAIN, 8'h00, 8'h00, 8'h00),
         check_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'd0, 10'd0, 10'd0, 1'b1),
         // pixels past the last row are ignored
         item_row(OP_PIXEL, 8'h5A, 8'h5A, 8'h5A),
         item_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF),
         check_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'd10, 10'd0, 10'd0, 1'b1),
         // register write in the middle of a frame starts over
         cfg_row(CSR_FRAME_WIDTH, 11'd5),
         item_row(OP_PIXEL, 8'h12, 8'h34, 8'h56),
         item_row(OP_PIXEL, 8'h78, 8'h9A, 8'hBC),
         cfg_row(CSR_FRAME_WIDTH, 11'd0),
         item_row(OP_PIXEL, 8'h2D, 8'h2D, 8'h2D),
         item_row(OP_DRAIN, 8'h00, 8'h00, 8'h00),
         check_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'd5, 10'd0, 10'd0, 1'b1),
         // height beyond the maximum is clamped, so row 0 is not the last
         cfg_row(CSR_FRAME_HEIGHT, 11'd2047),
         item_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF),
         item_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF),
         check_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'd56, 10'd0, 10'd0, 1'b0),
         // 2x2 frame with distinct channels
         cfg_row(CSR_FRAME_WIDTH, 11'd2),
         cfg_row(CSR_FRAME_HEIGHT, 11'd2),
         item_row(OP_PIXEL, 8'h01, 8'h80, 8'hFE),
         item_row(OP_PIXEL, 8'hFE, 8'h7F, 8'h01),
         item_row(OP_PIXEL, 8'h80, 8'h01, 8'h7F),
         item_row(OP_PIXEL, 8'h7F, 8'hFE, 8'h80),
         item_row(OP_DRAIN, 8'h00, 8'h00, 8'h00),
         item_row(OP_DRAIN, 8'h00, 8'h00, 8'h00),
         item_row(OP_DRAIN, 8'h00, 8'h00, 8'h00)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes: first pixels come out one row plus one position later
      send_frame(800, 600, 806, 1'b0, '1);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_cfg) write_reg(directed_plan[i].idx, directed_plan[i].data);
         else send_item(directed_plan[i].req, 1'b0, directed_plan[i].has_exp,
                        directed_plan[i].exp);
      end

      // widest row, then tallest column
      write_reg(CSR_FRAME_WIDTH, 11'd2047);
      write_reg(CSR_FRAME_HEIGHT, 11'd1);
      send_frame(LINE_MAX, 1, 2 * LINE_MAX + 1, 1'b0, 1030);
      write_reg(CSR_FRAME_WIDTH, 11'd1);
      write_reg(CSR_FRAME_HEIGHT, 11'd1024);
      send_frame(1, LINE_MAX, LINE_MAX + 2, 1'b0, '1);

      while (rand_sent < RAND_ITEMS) begin
         w_raw   = pick_size();
         h_raw   = pick_size();
         tx_idle = $urandom_range(0, 3) != 0;
         rx_idle = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 1)) begin
            write_reg(CSR_FRAME_WIDTH, w_raw);
            write_reg(CSR_FRAME_HEIGHT, h_raw);
         end else begin
            write_reg(CSR_FRAME_HEIGHT, h_raw);
            write_reg(CSR_FRAME_WIDTH, w_raw);
         end
         w = eff_size(w_raw);
         h = eff_size(h_raw);
         repeat ($urandom_range(1, 3)) begin
            len = w * h + w + 1;
            cut = len;
            // large frames and a few others are broken off part way
            if (len > 400 || $urandom_range(0, 7) == 0)
               cut = $urandom_range(1, (len > 400) ? 400 : len);
            send_frame(w, h, cut, 1'b1, '1);
            rand_sent += cut;
            if (cut < len) break;
         end
      end

      wait_drained();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
